[hw/rtl/integer_stack_calculator_assert.svh]
// Assertion macros used by the checker file of the stack calculator.
`ifndef INTEGER_STACK_CALCULATOR_ASSERT_SVH
`define INTEGER_STACK_CALCULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/isc_pkg.sv]
`default_nettype none

package isc_pkg;

  // Stack size and derived widths.
  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 7;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int DIV_STEPS   = DATA_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Command codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_RD_TOP = 3'd2,
    MODE_RD_BOT = 3'd3,
    MODE_ADD    = 3'd4,
    MODE_SUB    = 3'd5,
    MODE_MUL    = 3'd6,
    MODE_DIV    = 3'd7
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_RANGE    = 3'd2,
    STS_FEW      = 3'd3,
    STS_FULL_DIV = 3'd4
  } status_t;

  // What a stack cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,
    CELL_UP   = 2'd2
  } cell_op_t;

  // Request to the divider: start a floor division dividend / divisor.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // Divider status and result.
  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/isc_if.sv]
`default_nettype none

// Command channel: one command per item.
interface isc_cmd_if;
  import isc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] operand_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output mode, output operand_value, output position,
                  input ready);
  modport sink   (input valid, input mode, input operand_value, input position,
                  output ready);
endinterface

// Response channel: one result item per command.
interface isc_rsp_if;
  import isc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic [DEPTH_W-1:0]       depth_now;

  modport source (output valid, output result_value, output status, output depth_now,
                  input ready);
  modport sink   (input valid, input result_value, input status, input depth_now,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/isc_cell.sv]
`default_nettype none

// One stack entry. Entries shift toward the bottom on a push and toward
// the top on a pop; cell 0 is the top of the stack.
module isc_cell (
  input  wire logic                      clk,
  input  wire isc_pkg::cell_op_t         op,
  input  wire logic [isc_pkg::DATA_W-1:0] above,
  input  wire logic [isc_pkg::DATA_W-1:0] below,
  output      logic [isc_pkg::DATA_W-1:0] data
);
  import isc_pkg::*;

  // Entry register; contents are meaningless until written.
  always_ff @(posedge clk) begin
    case (op)
      CELL_DOWN: data <= above;
      CELL_UP:   data <= below;
      default:   data <= data;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/isc_div.sv]
`default_nettype none

// Signed floor divider: restoring division on magnitudes, one quotient
// bit per cycle, then a sign fix that rounds toward minus infinity.
module isc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire isc_pkg::div_req_t req,
  output      isc_pkg::div_rsp_t rsp
);
  import isc_pkg::*;

  logic              run;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dmag;
  logic              mixed;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dmag};
  assign fits    = ~diff[DATA_W];

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
    end else if (run && (step == STEP_W'(DIV_STEPS - 1))) begin
      run <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      step  <= '0;
      rem   <= '0;
      quo   <= req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      dmag  <= req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
      mixed <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (run) begin
      step <= step + 1'b1;
      rem  <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo  <= {quo[DATA_W-2:0], fits};
    end
  end

  // With mixed signs the truncated quotient is -quo; a nonzero remainder
  // moves it one further down, which is ~quo.
  always_comb begin
    rsp.busy = run;
    if (!mixed) begin
      rsp.quotient = quo;
    end else if (rem != '0) begin
      rsp.quotient = ~quo;
    end else begin
      rsp.quotient = ~quo + 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/integer_stack_calculator.sv]
`default_nettype none

// Sequencing: a command is taken only in S_IDLE and executed in S_EXEC; its
//   result is registered once the output register is free. A divide starts
//   the 32-step divider, which produces one quotient bit per cycle, and waits
//   in S_DIV for it. No new command is taken until the result is registered.
// Reset: the stack is empty and no result is pending; entries are not cleared.
module integer_stack_calculator (
  input  wire logic  clk,
  input  wire logic  rst,
  isc_cmd_if.sink    cmd,
  isc_rsp_if.source  rsp
);
  import isc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;

  // Latched command.
  mode_t             cmd_mode;
  logic [DATA_W-1:0] cmd_value;
  logic [POS_W-1:0]  cmd_pos;

  // Output register.
  logic                out_valid;
  logic [DATA_W-1:0]   out_result;
  status_t             out_status;
  logic [DEPTH_W-1:0]  out_depth;
  logic                out_free;

  // Stack cells.
  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  cell_op_t          op_top, op_rest;
  logic [DATA_W-1:0] top_load;

  // Divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Decode helpers.
  logic [DATA_W-1:0] opnd_b, opnd_c, arith;
  logic [CMP_W-1:0]  pos_x, cnt_x, idx_x;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_data;
  logic              finish;
  logic [DATA_W-1:0] res_c;
  status_t           sts_c;

  assign out_free = ~out_valid | rsp.ready;
  assign cmd.ready = (state == S_IDLE);

  // Operands: b is the top entry, c the one below it.
  assign opnd_b = cell_q[0];
  assign opnd_c = cell_q[1];

  // Read index, counted from the top.
  assign pos_x  = CMP_W'(cmd_pos);
  assign cnt_x  = CMP_W'(count);
  assign idx_x  = (cmd_mode == MODE_RD_TOP) ? pos_x : (cnt_x - 1'b1 - pos_x);
  assign rd_idx = idx_x[IDX_W-1:0];
  assign rd_data = cell_q[rd_idx];

  // Two-operand arithmetic other than divide.
  always_comb begin
    case (cmd_mode)
      MODE_SUB: arith = opnd_c - opnd_b;
      MODE_MUL: arith = opnd_c * opnd_b;
      default:  arith = opnd_c + opnd_b;
    endcase
  end

  // Command execution and control.
  always_comb begin
    state_next    = state;
    count_next    = count;
    op_top        = CELL_HOLD;
    op_rest       = CELL_HOLD;
    top_load      = cmd_value;
    finish        = 1'b0;
    res_c         = '0;
    sts_c         = STS_OK;
    div_req.start    = 1'b0;
    div_req.dividend = opnd_c;
    div_req.divisor  = opnd_b;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((cmd_mode == MODE_DIV) && (count >= CNT_W'(2)) && (opnd_b != '0)) begin
          div_req.start = 1'b1;
          state_next    = S_DIV;
        end else if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_mode) inside
            MODE_PUSH: begin
              if (count == CNT_W'(STACK_DEPTH)) begin
                sts_c = STS_FULL_DIV;
              end else begin
                op_top     = CELL_DOWN;
                op_rest    = CELL_DOWN;
                count_next = count + 1'b1;
                res_c      = cmd_value;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                sts_c = STS_EMPTY;
              end else begin
                op_top     = CELL_UP;
                op_rest    = CELL_UP;
                count_next = count - 1'b1;
                res_c      = opnd_b;
              end
            end
            MODE_RD_TOP, MODE_RD_BOT: begin
              if (pos_x >= cnt_x) begin
                sts_c = STS_RANGE;
              end else begin
                res_c = rd_data;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL: begin
              if (count < CNT_W'(2)) begin
                sts_c = STS_FEW;
              end else begin
                op_top     = CELL_DOWN;
                op_rest    = CELL_UP;
                top_load   = arith;
                count_next = count - 1'b1;
                res_c      = arith;
              end
            end
            MODE_DIV: begin
              // Too few operands or a zero divisor; the stack stays.
              sts_c = (count < CNT_W'(2)) ? STS_FEW : STS_FULL_DIV;
            end
            default: begin
              sts_c = STS_OK;
            end
          endcase
        end
      end
      S_DIV: begin
        if (!div_rsp.busy && out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          op_top     = CELL_DOWN;
          op_rest    = CELL_UP;
          top_load   = div_rsp.quotient;
          count_next = count - 1'b1;
          res_c      = div_rsp.quotient;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command latch and result payload.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_mode  <= mode_t'(cmd.mode);
      cmd_value <= cmd.operand_value;
      cmd_pos   <= cmd.position;
    end
    if (finish) begin
      out_result <= res_c;
      out_status <= sts_c;
      out_depth  <= DEPTH_W'(count_next);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_result;
  assign rsp.status       = out_status;
  assign rsp.depth_now    = out_depth;

  // Row of stack cells; cell 0 is the top.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = top_load;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    isc_cell u_cell (
      .clk   (clk),
      .op    ((i == 0) ? op_top : op_rest),
      .above (above),
      .below (below),
      .data  (cell_q[i])
    );
  end

  isc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

[hw/rtl/isc_checker.sv]
`default_nettype none

`include "integer_stack_calculator_assert.svh"

// Port-level checks of the stack calculator.
module isc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         cmd_valid,
  input wire logic                         cmd_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [isc_pkg::DATA_W-1:0]   rsp_result_value,
  input wire logic [isc_pkg::STATUS_W-1:0] rsp_status,
  input wire logic [isc_pkg::DEPTH_W-1:0]  rsp_depth_now
);
  import isc_pkg::*;

  // A stalled result item stays on the channel unchanged.
  `ISC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_depth_now), "stalled result item changed")

  // One command at a time: no command is taken right after another.
  `ISC_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

  // A failing command reports a zero value.
  `ISC_ASSERT_NOW(a_err_zero, clk, rst, rsp_valid && (rsp_status != STS_OK), rsp_result_value == '0, "error result carries a value")

  // An empty-stack pop leaves an empty stack.
  `ISC_ASSERT_NOW(a_empty_depth, clk, rst, rsp_valid && (rsp_status == STS_EMPTY), rsp_depth_now == '0, "empty status with nonzero depth")

  // Depth never exceeds the stack size.
  `ISC_ASSERT_NOW(a_depth_max, clk, rst, rsp_valid, rsp_depth_now <= DEPTH_W'(STACK_DEPTH), "depth beyond stack size")

endmodule

bind integer_stack_calculator isc_checker u_isc_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_status       (rsp.status),
  .rsp_depth_now    (rsp.depth_now)
);

`default_nettype wire

[verif/integer_stack_calculator_tb.sv]
`timescale 1ns / 1ps

module integer_stack_calculator_tb;
  import isc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_ITEMS    = 725;
  localparam int HOLD_AT         = 300;
  localparam int PAUSE_AT        = 520;
  localparam int MAX_REPORTS     = 10;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // One result item as the block should return it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [DEPTH_W-1:0]       depth;
  } stack_result_t;

  // Keeps a private copy of the stack and the queue of results still owed.
  class stack_scoreboard;
    logic [DATA_W-1:0] cells [STACK_DEPTH];
    int unsigned       depth;
    stack_result_t     expected_q [$];
    int                mismatches;
    int                checked;
    int                status_hits [5];
    int unsigned       peak_depth;

    function new();
      depth      = 0;
      mismatches = 0;
      checked    = 0;
      peak_depth = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Floored quotient; the one overflowing case wraps to the most negative word.
    function logic [DATA_W-1:0] floor_quotient(logic [DATA_W-1:0] num,
                                               logic [DATA_W-1:0] den);
      longint n;
      longint d;
      longint q;
      n = longint'($signed(num));
      d = longint'($signed(den));
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return DATA_W'(q);
    endfunction

    // Applies one accepted command to the stack copy and queues its result.
    function void note_command(mode_t mode, logic signed [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      stack_result_t     r;
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] below;
      r.value  = '0;
      r.status = STS_OK;
      case (mode)
        MODE_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            r.status = STS_FULL_DIV;
          end else begin
            cells[depth] = val;
            depth++;
            r.value = val;
          end
        end
        MODE_POP: begin
          if (depth == 0) begin
            r.status = STS_EMPTY;
          end else begin
            depth--;
            r.value = cells[depth];
          end
        end
        MODE_RD_TOP, MODE_RD_BOT: begin
          if (pos >= depth) begin
            r.status = STS_RANGE;
          end else if (mode == MODE_RD_TOP) begin
            r.value = cells[depth - 1 - pos];
          end else begin
            r.value = cells[pos];
          end
        end
        default: begin
          if (depth < 2) begin
            r.status = STS_FEW;
          end else begin
            top   = cells[depth - 1];
            below = cells[depth - 2];
            case (mode)
              MODE_ADD: r.value = below + top;
              MODE_SUB: r.value = below - top;
              MODE_MUL: r.value = below * top;
              default: begin
                if (top == '0) r.status = STS_FULL_DIV;
                else r.value = floor_quotient(below, top);
              end
            endcase
            // Both operands are replaced by the result only on success.
            if (r.status == STS_OK) begin
              depth--;
              cells[depth - 1] = r.value;
            end
          end
        end
      endcase
      r.depth = DEPTH_W'(depth);
      status_hits[r.status]++;
      if (depth > peak_depth) peak_depth = depth;
      expected_q.push_back(r);
    endfunction

    // Compares one returned item with the oldest outstanding result.
    function void check_result(logic signed [DATA_W-1:0] value,
                               logic [STATUS_W-1:0] status,
                               logic [DEPTH_W-1:0] depth_now);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ERROR: unexpected result value=%0d status=%0d depth=%0d",
                   $time, value, status, depth_now);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (value !== want.value || status !== want.status || depth_now !== want.depth) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t ERROR: result %0d expected value=%0d status=%0d depth=%0d,",
                    " got value=%0d status=%0d depth=%0d"}, $time, checked,
                   want.value, want.status, want.depth, value, status, depth_now);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_off_req;
  stack_scoreboard sb;

  isc_cmd_if cmd ();
  isc_rsp_if rsp ();

  integer_stack_calculator DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mix of boundary words, small signed values and full-range words.
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      4: return 1;
      5, 6: return DATA_W'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  // Offers one command from a falling edge and returns at the falling edge after it
  // was taken; valid is left high so back-to-back items need no reassertion.
  task automatic send_cmd(mode_t mode, logic signed [DATA_W-1:0] val,
                          logic [POS_W-1:0] pos);
    cmd.valid         <= 1'b1;
    cmd.mode          <= mode;
    cmd.operand_value <= val;
    cmd.position      <= pos;
    do @(posedge clk); while (!cmd.ready);
    sb.note_command(mode, val, pos);
    @(negedge clk);
  endtask

  task automatic idle(int cycles);
    cmd.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the command side off until every owed result has come back.
  task automatic wait_for_results();
    cmd.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Boundary words, every command and every error path but a full-stack push, on a short stack.
  task automatic run_directed();
    send_cmd(MODE_POP, random_word(), '0);
    send_cmd(MODE_RD_TOP, random_word(), '0);
    send_cmd(MODE_RD_BOT, random_word(), '1);
    send_cmd(MODE_ADD, random_word(), '0);
    send_cmd(MODE_PUSH, WORD_MIN, '0);
    send_cmd(MODE_DIV, random_word(), '0);
    send_cmd(MODE_PUSH, -1, '0);
    // Most negative over minus one wraps back to the most negative word.
    send_cmd(MODE_DIV, random_word(), '0);
    send_cmd(MODE_PUSH, '0, '0);
    send_cmd(MODE_DIV, random_word(), '0);
    send_cmd(MODE_RD_TOP, random_word(), 6'd1);
    send_cmd(MODE_RD_BOT, random_word(), 6'd1);
    send_cmd(MODE_RD_BOT, random_word(), 6'd2);
    send_cmd(MODE_POP, random_word(), '0);
    send_cmd(MODE_PUSH, WORD_MAX, '0);
    send_cmd(MODE_ADD, random_word(), '0);
    send_cmd(MODE_PUSH, 7, '0);
    send_cmd(MODE_PUSH, -2, '0);
    // Mixed signs with a remainder round toward minus infinity.
    send_cmd(MODE_DIV, random_word(), '0);
    send_cmd(MODE_PUSH, 3, '0);
    send_cmd(MODE_MUL, random_word(), '0);
    send_cmd(MODE_SUB, random_word(), '0);
    send_cmd(MODE_PUSH, WORD_MAX, '0);
    send_cmd(MODE_MUL, random_word(), '0);
    send_cmd(MODE_POP, random_word(), '0);
  endtask

  // Random commands in phases that lean toward filling or draining the stack.
  task automatic run_random();
    int               sent;
    int               burst_left;
    int               phase_left;
    int               push_pct;
    mode_t            mode;
    logic [POS_W-1:0] pos;
    sent       = 0;
    burst_left = 0;
    // The opening phase pushes hard enough to hit a full stack.
    phase_left = 100;
    push_pct   = 95;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 45;
          default: push_pct = 15;
        endcase
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 10));
      end
      // Results back up while the receiver is held off; keep offering items.
      if (sent == HOLD_AT) begin
        hold_off_req = 1'b1;
        burst_left   = 40;
      end
      if (sent == PAUSE_AT) wait_for_results();

      if ($urandom_range(0, 99) < push_pct) mode = MODE_PUSH;
      else mode = mode_t'($urandom_range(1, 7));
      if (sb.depth != 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, sb.depth - 1));
      else
        pos = POS_W'($urandom_range(0, 63));

      send_cmd(mode, random_word(), pos);
      sent++;
      burst_left--;
      phase_left--;
    end
  endtask

  // Result side: a rotating stall pattern, reshuffled now and then, plus one long hold-off.
  initial begin
    logic [15:0] pattern;
    int          hold_left;
    int          reshuffle;
    rsp.ready = 1'b0;
    pattern   = '1;
    hold_left = 0;
    reshuffle = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (reshuffle == 0) begin
          reshuffle = $urandom_range(16, 96);
          pattern   = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        end
        reshuffle--;
        rsp.ready <= pattern[0];
        pattern   = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Every returned item is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check_result(rsp.result_value, rsp.status, rsp.depth_now);
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence.
  initial begin
    sb                = new();
    rst               = 1'b1;
    hold_off_req      = 1'b0;
    cmd.valid         = 1'b0;
    cmd.mode          = MODE_PUSH;
    cmd.operand_value = '0;
    cmd.position      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d empty pops, %0d out-of-range reads,",
             sb.checked, sb.status_hits[STS_OK], sb.status_hits[STS_EMPTY],
             sb.status_hits[STS_RANGE]);
    $display("%0d short-operand ops, %0d full pushes or zero divides, peak depth %0d of %0d.",
             sb.status_hits[STS_FEW], sb.status_hits[STS_FULL_DIV], sb.peak_depth,
             STACK_DEPTH);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, results never returned: %0d", sb.mismatches,
               sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
